FILE: sv/ptm_pkg.sv
// Package for the pulse train meter and count decoder.
// Holds widths, codes and the controller/datapath command and status structs.
// No dependencies.
package ptm_pkg;

  localparam int unsigned MAX_PULSES = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_PULSES);
  localparam int unsigned CNT_W      = $clog2(MAX_PULSES + 1);
  localparam int unsigned DIV_W      = 58;
  localparam int unsigned DIVC_W     = $clog2(DIV_W);

  localparam logic [31:0] U32MAX     = 32'hFFFF_FFFF;
  localparam logic [25:0] RATE_K     = 26'd60000000;
  localparam logic [31:0] PAUSE_MAX  = 32'd1000;

  localparam logic [2:0] CFG_FILTER_MODE  = 3'd0;
  localparam logic [2:0] CFG_FILTER_TIME  = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT_TIME = 3'd2;
  localparam logic [2:0] CFG_INITIAL_TIME = 3'd3;
  localparam logic [2:0] CFG_TOTAL_ENABLE = 3'd4;

  localparam logic [1:0] PH_INITIAL  = 2'd0;
  localparam logic [1:0] PH_WAITING  = 2'd1;
  localparam logic [1:0] PH_RUNNING  = 2'd2;
  localparam logic [1:0] PH_TIMEDOUT = 2'd3;

  localparam logic [1:0] KIND_TOTAL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;
  localparam logic [1:0] KIND_ZERO  = 2'd3;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic latch;
    logic exec;
    logic mul;
    logic div_step;
    logic rate_push;
    logic dec_rd;
    logic dec_chk;
    logic dec_end;
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    logic       op;
    logic       cnt_nz;
    logic       run_phase;
    logic       timeout_hit;
    logic       tot_en;
    logic       delta_zero;
    logic       div_last;
    logic       dec_more;
    logic       dec_stop;
    logic [1:0] nres;
    logic       last;
  } stat_t;

endpackage

FILE: sv/ptm_if.sv
// Channel interfaces: input events, results and configuration writes.
// Depends on nothing.
interface ptm_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] time_us;
  logic        pin_level;
  modport source (output valid, op, time_us, pin_level, input ready);
  modport sink (input valid, op, time_us, pin_level, output ready);
endinterface

interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] value;
  logic        last;
  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface

interface ptm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pulse_train_meter_and_count_decoder.sv
// Channel   Dir  Payload                         Beat
// in_i      in   op, time_us, pin_level          valid & ready
// out_o     out  kind, value, last               valid & ready
// cfg_i     in   index (3b), data (32b)          valid & ready (always ready)
// One item at a time. Pin event and quiet poll: latch, then execute; total only adds the beat.
// Rate poll: multiply, then the one-bit-per-cycle 58-step divider unless delta is zero.
// Timeout poll: decode walk over up to 64 table entries, one memory read each.
// Async reset (active low) clears config/control state; tables clear by valid bits at once.
// A stalled result holds the block until taken; cfg writes apply any time.
module pulse_train_meter_and_count_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptm_in_if.sink    in_i,
  ptm_out_if.source out_o,
  ptm_cfg_if.sink   cfg_i
);

  ptm_pkg::cmd_t  cmd;
  ptm_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;
  assign out_o.last  = stat.last;

  ptm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_op_i     (in_i.op),
    .in_time_i   (in_i.time_us),
    .in_pin_i    (in_i.pin_level),
    .out_kind_o  (out_o.kind),
    .out_value_o (out_o.value)
  );

endmodule

FILE: sv/ptm_dp.sv
// Datapath: config registers, filter state, pulse tables, rate divider, decoder.
// Depends on ptm_pkg; driven by ptm_ctrl commands.
module ptm_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptm_pkg::cmd_t        cmd_i,
  output ptm_pkg::stat_t       stat_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_op_i,
  input  logic [31:0]          in_time_i,
  input  logic                 in_pin_i,
  output logic [1:0]           out_kind_o,
  output logic [31:0]          out_value_o
);

  logic        mode_q, tot_en_q;
  logic [31:0] ftime_q, tout_q, ipt_q;

  logic        op_q, pin_q;
  logic [31:0] now_q;

  logic [1:0]  phase_q;
  logic [31:0] lct_q, cand_q, pend_q, pedge_q, polled_q, proc_q, total_q;
  logic        level_q, inside_q;
  logic [ptm_pkg::CNT_W-1:0] rec_q;

  logic [31:0] len_mem [ptm_pkg::MAX_PULSES];
  logic [31:0] pau_mem [ptm_pkg::MAX_PULSES];
  logic [ptm_pkg::MAX_PULSES-1:0] len_v_q, pau_v_q;

  logic [31:0] cnt_q, delta_q;
  logic [ptm_pkg::DIV_W-1:0]  quo_q;
  logic [32:0]                rem_q;
  logic [ptm_pkg::DIVC_W-1:0] divc_q;

  logic [ptm_pkg::CNT_W-1:0] idx_q, n_q;
  logic        seen_q;
  logic [31:0] rd_len_q, rd_pau_q;
  logic        rd_lv_q, rd_pv_q;

  logic [1:0]  kind_q [2];
  logic [31:0] val_q  [2];
  logic [1:0]  nres_q;
  logic        ptr_q;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ptm_pkg::U32MAX : s[31:0];
  endfunction

  // Filter evaluation
  logic [31:0] d_cand, d_lct, rlen;
  logic        rec_full, do_rec, do_pause;
  logic [ptm_pkg::CNT_W-1:0] prec;
  logic [ptm_pkg::IDX_W-1:0] paddr;
  always_comb begin
    d_cand   = now_q - cand_q;
    d_lct    = now_q - lct_q;
    rec_full = (rec_q >= ptm_pkg::CNT_W'(ptm_pkg::MAX_PULSES));
    do_rec   = 1'b0;
    do_pause = 1'b0;
    rlen     = d_cand;
    if (mode_q == 1'b0) begin
      do_rec = (d_cand >= ftime_q);
    end else if (level_q != pin_q && d_lct > ftime_q) begin
      do_pause = !inside_q && !pin_q;
      do_rec   = inside_q && pin_q;
    end
    prec  = (rec_q == '0) ? ptm_pkg::CNT_W'(1) : rec_q;
    paddr = ptm_pkg::IDX_W'(prec - ptm_pkg::CNT_W'(1));
  end

  logic        pin_go, poll_go, go_run;
  logic [31:0] new_total;
  assign pin_go    = cmd_i.exec && (op_q == ptm_pkg::OP_PIN);
  assign poll_go   = cmd_i.exec && (op_q == ptm_pkg::OP_POLL);
  assign new_total = sat_add(total_q, pend_q);
  assign go_run    = (phase_q == ptm_pkg::PH_WAITING) && (pedge_q - proc_q > ipt_q);

  // Divider step
  logic [32:0] div_t;
  logic        div_bit;
  assign div_t   = {rem_q[31:0], quo_q[ptm_pkg::DIV_W-1]};
  assign div_bit = (div_t >= {1'b0, delta_q});

  // Decode check
  logic [31:0] dl, dpz;
  logic [35:0] l10, lo, hi;
  logic        first_hit;
  always_comb begin
    dl        = rd_lv_q ? rd_len_q : '0;
    dpz       = rd_pv_q ? rd_pau_q : '0;
    l10       = {1'b0, dl, 3'b0} + {3'b0, dl, 1'b0};
    lo        = {1'b0, ipt_q, 3'b0} + {4'b0, ipt_q};
    hi        = {1'b0, ipt_q, 3'b0} + {3'b0, ipt_q, 1'b0} + {4'b0, ipt_q};
    first_hit = !seen_q && (l10 > lo) && (l10 < hi);
  end

  logic [31:0] rate_val;
  assign rate_val = (delta_q == '0 || |quo_q[ptm_pkg::DIV_W-1:32]) ? ptm_pkg::U32MAX
                                                                   : quo_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b1;
      ftime_q   <= 32'd13;
      tout_q    <= 32'd5000000;
      ipt_q     <= 32'd200000;
      tot_en_q  <= 1'b1;
      phase_q   <= ptm_pkg::PH_INITIAL;
      lct_q     <= '0;
      level_q   <= 1'b0;
      inside_q  <= 1'b0;
      cand_q    <= '0;
      pend_q    <= '0;
      pedge_q   <= '0;
      polled_q  <= '0;
      proc_q    <= '0;
      total_q   <= '0;
      rec_q     <= '0;
      len_v_q   <= '0;
      pau_v_q   <= '0;
      nres_q    <= '0;
      ptr_q     <= 1'b0;
      idx_q     <= '0;
      n_q       <= '0;
      seen_q    <= 1'b0;
      divc_q    <= '0;
      kind_q[0] <= ptm_pkg::KIND_TOTAL;
      kind_q[1] <= ptm_pkg::KIND_TOTAL;
      val_q[0]  <= '0;
      val_q[1]  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ptm_pkg::CFG_FILTER_MODE:  mode_q   <= cfg_data_i[0];
          ptm_pkg::CFG_FILTER_TIME:  ftime_q  <= cfg_data_i;
          ptm_pkg::CFG_TIMEOUT_TIME: tout_q   <= cfg_data_i;
          ptm_pkg::CFG_INITIAL_TIME: ipt_q    <= cfg_data_i;
          ptm_pkg::CFG_TOTAL_ENABLE: tot_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.latch) begin
        nres_q <= '0;
        ptr_q  <= 1'b0;
      end
      if (pin_go) begin
        if (mode_q == 1'b0) begin
          if (do_rec) begin
            cand_q  <= now_q;
            pedge_q <= now_q;
            pend_q  <= sat_add(pend_q, 32'd1);
          end
        end else begin
          if (level_q == pin_q) begin
            if (d_lct < ftime_q) lct_q <= now_q;
          end else begin
            if (do_pause) begin
              rec_q    <= prec;
              pau_v_q[paddr] <= 1'b1;
              cand_q   <= lct_q;
              inside_q <= 1'b1;
            end else if (do_rec) begin
              pedge_q  <= cand_q;
              pend_q   <= sat_add(pend_q, 32'd1);
              inside_q <= 1'b0;
            end
            lct_q   <= now_q;
            level_q <= pin_q;
          end
        end
        if (do_rec && !rec_full) begin
          len_v_q[ptm_pkg::IDX_W'(rec_q)] <= 1'b1;
          rec_q <= rec_q + ptm_pkg::CNT_W'(1);
        end
      end
      if (poll_go) begin
        pend_q   <= '0;
        polled_q <= pedge_q;
        idx_q    <= '0;
        n_q      <= '0;
        seen_q   <= 1'b0;
        if (pend_q != '0) begin
          if (tot_en_q) begin
            if (!go_run) total_q <= new_total;
            kind_q[0] <= ptm_pkg::KIND_TOTAL;
            val_q[0]  <= new_total;
            nres_q    <= 2'd1;
          end
          case (phase_q)
            ptm_pkg::PH_INITIAL, ptm_pkg::PH_TIMEDOUT: phase_q <= ptm_pkg::PH_WAITING;
            ptm_pkg::PH_WAITING: begin
              if (go_run) begin
                total_q <= '0;
                phase_q <= ptm_pkg::PH_RUNNING;
              end
            end
            default: ;
          endcase
          proc_q <= pedge_q;
        end else if (stat_o.timeout_hit) begin
          phase_q <= ptm_pkg::PH_TIMEDOUT;
        end
      end
      if (cmd_i.mul) divc_q <= '0;
      if (cmd_i.div_step) divc_q <= divc_q + ptm_pkg::DIVC_W'(1);
      if (cmd_i.rate_push) begin
        kind_q[nres_q[0]] <= ptm_pkg::KIND_RATE;
        val_q[nres_q[0]]  <= rate_val;
        nres_q <= nres_q + 2'd1;
      end
      if (cmd_i.dec_chk) begin
        idx_q <= idx_q + ptm_pkg::CNT_W'(1);
        if (first_hit) seen_q <= 1'b1;
        else if (seen_q) n_q <= n_q + ptm_pkg::CNT_W'(1);
      end
      if (cmd_i.dec_end) begin
        kind_q[nres_q[0]] <= (n_q != '0) ? ptm_pkg::KIND_COUNT : ptm_pkg::KIND_ZERO;
        val_q[nres_q[0]]  <= 32'(n_q);
        nres_q  <= nres_q + 2'd1;
        rec_q   <= '0;
        len_v_q <= '0;
        pau_v_q <= '0;
      end
      if (cmd_i.out_pop) ptr_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= in_op_i;
      now_q <= in_time_i;
      pin_q <= in_pin_i;
    end
    if (poll_go) begin
      cnt_q   <= pend_q;
      delta_q <= pedge_q - proc_q;
    end
    if (cmd_i.mul) begin
      quo_q <= ptm_pkg::DIV_W'(ptm_pkg::RATE_K) * ptm_pkg::DIV_W'(cnt_q);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_bit ? (div_t - {1'b0, delta_q}) : div_t;
      quo_q <= {quo_q[ptm_pkg::DIV_W-2:0], div_bit};
    end
    if (pin_go && do_rec && !rec_full) len_mem[ptm_pkg::IDX_W'(rec_q)] <= rlen;
    if (pin_go && mode_q && do_pause) pau_mem[paddr] <= now_q - polled_q;
    if (cmd_i.dec_rd) begin
      rd_len_q <= len_mem[ptm_pkg::IDX_W'(idx_q)];
      rd_pau_q <= pau_mem[ptm_pkg::IDX_W'(idx_q)];
      rd_lv_q  <= len_v_q[ptm_pkg::IDX_W'(idx_q)];
      rd_pv_q  <= pau_v_q[ptm_pkg::IDX_W'(idx_q)];
    end
  end

  always_comb begin
    stat_o.op          = op_q;
    stat_o.cnt_nz      = (pend_q != '0);
    stat_o.run_phase   = (phase_q == ptm_pkg::PH_RUNNING);
    stat_o.timeout_hit = (phase_q != ptm_pkg::PH_TIMEDOUT) && (now_q - proc_q > tout_q);
    stat_o.tot_en      = tot_en_q;
    stat_o.delta_zero  = (delta_q == '0);
    stat_o.div_last    = (divc_q == ptm_pkg::DIVC_W'(ptm_pkg::DIV_W - 1));
    stat_o.dec_more    = (idx_q < rec_q);
    stat_o.dec_stop    = !first_hit && (dl != '0) && (dpz > ptm_pkg::PAUSE_MAX);
    stat_o.nres        = nres_q;
    stat_o.last        = ({1'b0, ptr_q} == nres_q - 2'd1);
  end

  assign out_kind_o  = kind_q[ptr_q];
  assign out_value_o = val_q[ptr_q];

endmodule

FILE: sv/ptm_ctrl.sv
// Controller FSM: sequences filter, poll, rate divide, decode walk and result beats.
// Depends on ptm_pkg; drives ptm_dp through cmd_t and reads stat_t.
module ptm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ptm_pkg::stat_t stat_i,
  output ptm_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RPUSH  = 4'd4;
  localparam logic [3:0] S_DECRD  = 4'd5;
  localparam logic [3:0] S_DECCHK = 4'd6;
  localparam logic [3:0] S_DECEND = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.op == ptm_pkg::OP_PIN) state_d = S_IDLE;
        else if (stat_i.cnt_nz) begin
          if (stat_i.run_phase) state_d = S_MUL;
          else if (stat_i.tot_en) state_d = S_OUT;
          else state_d = S_IDLE;
        end else if (stat_i.timeout_hit) state_d = S_DECRD;
        else state_d = S_IDLE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = stat_i.delta_zero ? S_RPUSH : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_RPUSH;
      end
      S_RPUSH: begin
        cmd_o.rate_push = 1'b1;
        state_d         = S_OUT;
      end
      S_DECRD: begin
        if (stat_i.dec_more) begin
          cmd_o.dec_rd = 1'b1;
          state_d      = S_DECCHK;
        end else state_d = S_DECEND;
      end
      S_DECCHK: begin
        cmd_o.dec_chk = 1'b1;
        state_d       = stat_i.dec_stop ? S_DECEND : S_DECRD;
      end
      S_DECEND: begin
        cmd_o.dec_end = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_pop = 1'b1;
          if (stat_i.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output overlap");
  a_out_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> stat_i.nres != 2'd0) else $error("beat without result");
`endif

endmodule
